### design/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// types, protocol constants and the crc-16 byte step for the sensor responder
// ----------------------------------------------------------------------------
package rss_pkg;

    typedef logic [7:0]         byte_t;
    typedef logic signed [15:0] reading_t;
    typedef logic [15:0]        crc_t;

    localparam crc_t  CRC_POLY      = 16'hA001;
    localparam crc_t  CRC_INIT      = 16'hFFFF;
    localparam byte_t BCAST_ADDR    = 8'hFE;
    localparam byte_t FN_READ       = 8'h03;
    localparam byte_t FN_WRITE_ADDR = 8'h06;
    localparam byte_t BYTE_COUNT    = 8'h04;
    localparam byte_t DEFAULT_ADDR  = 8'h20;
    localparam int    FIXED_LEN     = 9;

    // reply byte counter, 0 .. 8
    localparam int IDX_W = 4;
    typedef logic [IDX_W-1:0] idx_t;
    localparam idx_t LAST_IDX    = idx_t'(FIXED_LEN - 1);
    localparam idx_t CRC_LO_IDX  = idx_t'(7);
    localparam idx_t NEW_ADDR_IDX = idx_t'(6);

    typedef enum logic [1:0] {
        MODE_BCAST = 2'd0,
        MODE_READ  = 2'd1,
        MODE_ECHO  = 2'd2
    } mode_t;

    // reflected crc-16, one byte, eight shift steps
    function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
        crc_t c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/rss_in_if.sv
// ----------------------------------------------------------------------------
// rss_in_if
// receive channel: one frame byte per beat plus the sampled sensor readings
// ----------------------------------------------------------------------------
interface rss_in_if;
    import rss_pkg::*;

    logic     valid;
    logic     ready;
    byte_t    rx_byte;
    logic     frame_end;
    reading_t temperature_reading;
    reading_t conductivity_reading;

    modport source (
        output valid, rx_byte, frame_end, temperature_reading, conductivity_reading,
        input  ready
    );
    modport sink (
        input  valid, rx_byte, frame_end, temperature_reading, conductivity_reading,
        output ready
    );
endinterface

### design/rss_out_if.sv
// ----------------------------------------------------------------------------
// rss_out_if
// transmit channel: one response byte per beat with a last-byte mark
// ----------------------------------------------------------------------------
interface rss_out_if;
    import rss_pkg::*;

    logic  valid;
    logic  ready;
    byte_t tx_byte;
    logic  tx_last;

    modport source (
        output valid, tx_byte, tx_last,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, tx_last,
        output ready
    );
endinterface

### design/rs485_sensor_slave_responder.sv
// ----------------------------------------------------------------------------
// rs485_sensor_slave_responder
// modbus-rtu style slave: checks the frame crc and answers with nine bytes
// ----------------------------------------------------------------------------
//  channel  dir  beat                                     accepted when
//  rx       in   rx_byte, frame_end, two sensor readings  rx.valid && rx.ready
//  tx       out  tx_byte, tx_last                         tx.valid && tx.ready
//  cfg      in   cfg_wdata (reset address)                cfg_we
//
// a received byte is written to the frame ram, while it has room, and folded
// into the crc in the same cycle. a frame end with a good crc and at least
// two bytes leads to the decode state; each reply byte then passes through
// fetch (ram read) and load (into the output register), and tx stalls
// stretch the load state. the frame ram needs no clearing after reset.
// the node address comes up as 0x20; the reset address register is itself
// reset to 0x20 first, so a value written there never reaches the node address.
// ----------------------------------------------------------------------------
module rs485_sensor_slave_responder #(
    parameter int MAX_FRAME = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    rss_in_if.sink              rx,
    rss_out_if.source           tx,
    input  logic                cfg_we,
    input  rss_pkg::byte_t      cfg_wdata
);
    import rss_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int LEN_W  = $clog2(MAX_FRAME + 1);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_FRAME);
    localparam logic [LEN_W-1:0] LEN_FIXED = LEN_W'(FIXED_LEN);
    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);

    typedef enum logic [3:0] {
        S_RX    = 4'b0001,
        S_DEC   = 4'b0010,
        S_FETCH = 4'b0100,
        S_LOAD  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [LEN_W-1:0] flen_reg, flen_next;
    crc_t             crc_reg, crc_next;
    crc_t             crc_tx_reg, crc_tx_next;
    byte_t            node_addr_reg, node_addr_next;
    byte_t            reset_addr_reg, reset_addr_next;
    logic             addr_load_reg, addr_load_next;
    byte_t            a0_reg, a0_next;
    byte_t            fn_reg, fn_next;
    reading_t         temp_reg, temp_next;
    reading_t         cond_reg, cond_next;
    mode_t            mode_reg, mode_next;
    idx_t             idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    byte_t            tx_byte_reg, tx_byte_next;
    logic             tx_last_reg, tx_last_next;

    logic             rx_acc;
    logic             ram_we;
    byte_t            ram_rdata;
    crc_t             crc_upd;
    logic [LEN_W-1:0] len_upd;
    logic             out_free;
    logic             load;
    byte_t            body_byte;

    rss_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (frame_len_reg[ADDR_W-1:0]),
        .wdata (rx.rx_byte),
        .raddr (ADDR_W'(idx_reg)),
        .rdata (ram_rdata)
    );

    assign rx.ready   = (state_reg == S_RX);
    assign rx_acc     = rx.valid && rx.ready;
    assign ram_we     = rx_acc && (frame_len_reg < LEN_MAX);
    assign crc_upd    = crc_byte(crc_reg, rx.rx_byte);
    assign len_upd    = (frame_len_reg < LEN_MAX) ? frame_len_reg + 1'b1 : frame_len_reg;
    assign out_free   = !out_valid_reg || tx.ready;
    assign load       = (state_reg == S_LOAD) && out_free;

    assign tx.valid   = out_valid_reg;
    assign tx.tx_byte = tx_byte_reg;
    assign tx.tx_last = tx_last_reg;

    // reply byte for the current index
    always_comb
    begin
        body_byte = 8'h00;
        if (mode_reg == MODE_ECHO)
        begin
            body_byte = ram_rdata;
        end
        else
        begin
            case (idx_reg)
                4'd0:    body_byte = (mode_reg == MODE_BCAST) ? BCAST_ADDR : node_addr_reg;
                4'd1:    body_byte = FN_READ;
                4'd2:    body_byte = BYTE_COUNT;
                4'd3:    body_byte = (mode_reg == MODE_BCAST) ? node_addr_reg : temp_reg[15:8];
                4'd4:    body_byte = (mode_reg == MODE_BCAST) ? 8'h00 : temp_reg[7:0];
                4'd5:    body_byte = (mode_reg == MODE_BCAST) ? 8'h00 : cond_reg[15:8];
                4'd6:    body_byte = (mode_reg == MODE_BCAST) ? 8'h00 : cond_reg[7:0];
                4'd7:    body_byte = crc_tx_reg[7:0];
                default: body_byte = crc_tx_reg[15:8];
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        frame_len_next  = frame_len_reg;
        flen_next       = flen_reg;
        crc_next        = crc_reg;
        crc_tx_next     = crc_tx_reg;
        node_addr_next  = node_addr_reg;
        reset_addr_next = reset_addr_reg;
        addr_load_next  = 1'b0;
        a0_next         = a0_reg;
        fn_next         = fn_reg;
        temp_next       = temp_reg;
        cond_next       = cond_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        tx_byte_next    = tx_byte_reg;
        tx_last_next    = tx_last_reg;

        if (cfg_we)
        begin
            reset_addr_next = cfg_wdata;
        end

        // first cycle out of reset takes the node address from the register
        if (addr_load_reg)
        begin
            node_addr_next = reset_addr_reg;
        end

        if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_RX:
            begin
                if (rx_acc)
                begin
                    if (frame_len_reg == '0)
                    begin
                        a0_next = rx.rx_byte;
                    end
                    if (frame_len_reg == LEN_W'(1))
                    begin
                        fn_next = rx.rx_byte;
                    end
                    if (rx.frame_end)
                    begin
                        temp_next      = rx.temperature_reading;
                        cond_next      = rx.conductivity_reading;
                        flen_next      = len_upd;
                        frame_len_next = '0;
                        crc_next       = CRC_INIT;
                        if (crc_upd == 16'h0000 && len_upd >= LEN_MIN)
                        begin
                            state_next = S_DEC;
                        end
                    end
                    else
                    begin
                        frame_len_next = len_upd;
                        crc_next       = crc_upd;
                    end
                end
            end
            S_DEC:
            begin
                idx_next    = '0;
                crc_tx_next = CRC_INIT;
                state_next  = S_RX;
                if (fn_reg == FN_READ)
                begin
                    if (a0_reg == BCAST_ADDR && flen_reg == LEN_FIXED)
                    begin
                        mode_next  = MODE_BCAST;
                        state_next = S_FETCH;
                    end
                    else if (a0_reg == node_addr_reg)
                    begin
                        mode_next  = MODE_READ;
                        state_next = S_FETCH;
                    end
                end
                else if (fn_reg == FN_WRITE_ADDR && a0_reg == node_addr_reg
                         && flen_reg == LEN_FIXED)
                begin
                    mode_next  = MODE_ECHO;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // ram read for idx is in flight
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tx_byte_next   = body_byte;
                    tx_last_next   = (idx_reg == LAST_IDX);
                    if (idx_reg < CRC_LO_IDX)
                    begin
                        crc_tx_next = crc_byte(crc_tx_reg, body_byte);
                    end
                    if (mode_reg == MODE_ECHO && idx_reg == NEW_ADDR_IDX)
                    begin
                        node_addr_next = ram_rdata;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_RX;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RX;
            frame_len_reg  <= '0;
            crc_reg        <= CRC_INIT;
            node_addr_reg  <= DEFAULT_ADDR;
            reset_addr_reg <= DEFAULT_ADDR;
            addr_load_reg  <= 1'b1;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            frame_len_reg  <= frame_len_next;
            crc_reg        <= crc_next;
            node_addr_reg  <= node_addr_next;
            reset_addr_reg <= reset_addr_next;
            addr_load_reg  <= addr_load_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flen_reg    <= flen_next;
        crc_tx_reg  <= crc_tx_next;
        a0_reg      <= a0_next;
        fn_reg      <= fn_next;
        temp_reg    <= temp_next;
        cond_reg    <= cond_next;
        mode_reg    <= mode_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
    end

    // frame length never runs past the store
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_len_reg <= LEN_MAX)
        else $error("frame length beyond store depth");

    // a frame end with good crc and length goes to decode
    a_dec_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rx_acc && rx.frame_end && crc_upd == 16'h0000 && len_upd >= LEN_MIN
        |=> state_reg == S_DEC)
        else $error("good frame end did not reach decode");

    // the reply counter stays within nine bytes while sending
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH || state_reg == S_LOAD) |-> idx_reg <= LAST_IDX)
        else $error("reply index out of range");

    // loading the ninth byte marks it last and frees the receiver
    a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
        load && idx_reg == LAST_IDX |=> out_valid_reg && tx_last_reg && state_reg == S_RX)
        else $error("final reply byte not marked last");

    // no byte is taken while the reply is in the fetch or load state
    a_no_rx_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH || state_reg == S_LOAD) |-> !rx.ready)
        else $error("receiver open during reply");

endmodule

### design/rss_ram.sv
// ----------------------------------------------------------------------------
// rss_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
